/* hdl/uart_buffer_shifter_peripheral_defines.svh */
// assertion macros for the uart buffer/shifter peripheral checker
// no dependencies; included by the checker file only
`ifndef UART_BUFFER_SHIFTER_PERIPHERAL_DEFINES_SVH
`define UART_BUFFER_SHIFTER_PERIPHERAL_DEFINES_SVH

// same-cycle implication, gated by reset
`define UBS_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, gated by reset
`define UBS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ubs_pkg.sv */
// shared types, codes and constants of the uart buffer/shifter peripheral
// no dependencies; used by every other file except the defines header, through scoped names
package ubs_pkg;

   localparam int WAIT_WIDTH_DEF = 20;
   localparam int DIV_WIDTH      = 18;
   localparam int STEP_WIDTH     = 16;

   // request operation codes
   typedef enum logic [2:0] {
      FUNC_READ    = 3'd0,
      FUNC_WRITE   = 3'd1,
      FUNC_TICK    = 3'd2,
      FUNC_RX_BYTE = 3'd3,
      FUNC_TX_POLL = 3'd4
   } func_type;

   // register map
   typedef enum logic [3:0] {
      REG_CTL0   = 4'd0,
      REG_CTL1   = 4'd1,
      REG_BR0    = 4'd2,
      REG_BR1    = 4'd3,
      REG_MCTL   = 4'd4,
      REG_STAT   = 4'd5,
      REG_RXBUF  = 4'd6,
      REG_TXBUF  = 4'd7,
      REG_ABCTL  = 4'd8,
      REG_IRTCTL = 4'd9,
      REG_IRRCTL = 4'd10,
      REG_IEIFG  = 4'd11
   } reg_type;

   // result event codes
   typedef enum logic [1:0] {
      EVT_OK       = 2'd0,
      EVT_BAD_REG  = 2'd1,
      EVT_RX_DROP  = 2'd2,
      EVT_READONLY = 2'd3
   } event_type;

   // clock select codes in ctl1[7:6]
   localparam logic [1:0] CLKSEL_NONE = 2'd0;
   localparam logic [1:0] CLKSEL_ACLK = 2'd1;

   // bit positions
   localparam int CTL0_7BIT  = 4;
   localparam int CTL1_SWRST = 0;
   localparam int STAT_OE    = 5;
   localparam int STAT_FE    = 6;
   localparam int IRQ_RXIE   = 0;
   localparam int IRQ_TXIE   = 1;
   localparam int IRQ_RXIFG  = 2;
   localparam int IRQ_TXIFG  = 3;

   typedef struct packed {
      logic [2:0]            func;
      logic [3:0]            reg_index;
      logic [7:0]            data_in;
      logic [STEP_WIDTH-1:0] aclk_step;
      logic [STEP_WIDTH-1:0] smclk_step;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_free;
      logic       rx_irq;
      logic       tx_irq;
      logic       rx_dma_pulse;
      logic       tx_dma_pulse;
      logic [1:0] event_code;
   } rsp_type;

   // bits per character (eight, or seven with the ctl0 7-bit flag) times half the baud divider
   function automatic logic [DIV_WIDTH-1:0] byte_div(input logic [7:0] ctl0,
                                                     input logic [7:0] br_hi,
                                                     input logic [7:0] br_lo);
      logic [DIV_WIDTH-1:0] half;
      logic [DIV_WIDTH-1:0] times8;
      half   = {{(DIV_WIDTH-15){1'b0}}, br_hi, br_lo[7:1]};
      times8 = {half[DIV_WIDTH-4:0], 3'b000};
      byte_div = ctl0[CTL0_7BIT] ? (times8 - half) : times8;
   endfunction

endpackage

/* hdl/ubs_if.sv */
// request and response channel interfaces of the uart buffer/shifter peripheral
// depends on ubs_pkg for field widths
interface ubs_req_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       func;
   logic [3:0]                       reg_index;
   logic [7:0]                       data_in;
   logic [ubs_pkg::STEP_WIDTH-1:0]   aclk_step;
   logic [ubs_pkg::STEP_WIDTH-1:0]   smclk_step;

   modport source (output valid, func, reg_index, data_in, aclk_step, smclk_step,
                   input ready);
   modport sink   (input valid, func, reg_index, data_in, aclk_step, smclk_step,
                   output ready);
endinterface

interface ubs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       rx_free;
   logic       rx_irq;
   logic       tx_irq;
   logic       rx_dma_pulse;
   logic       tx_dma_pulse;
   logic [1:0] event_code;

   modport source (output valid, read_data, tx_valid, tx_byte, rx_free, rx_irq, tx_irq,
                   rx_dma_pulse, tx_dma_pulse, event_code, input ready);
   modport sink   (input valid, read_data, tx_valid, tx_byte, rx_free, rx_irq, tx_irq,
                   rx_dma_pulse, tx_dma_pulse, event_code, output ready);
endinterface

/* hdl/ubs_core.sv */
// register file, buffers, shifters and wait counters of the uart peripheral
// depends on ubs_pkg; updates state once per fired request, result is combinational
module ubs_core #(
   parameter int WAIT_WIDTH = ubs_pkg::WAIT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  ubs_pkg::req_type req,
   output ubs_pkg::rsp_type rsp
);

   localparam int W  = WAIT_WIDTH;
   localparam int DW = ubs_pkg::DIV_WIDTH;
   localparam int SW = ubs_pkg::STEP_WIDTH;

   // architectural state
   logic [7:0]    ctl0_ff, ctl0_in, ctl1_ff, ctl1_in, br0_ff, br0_in, br1_ff, br1_in;
   logic [7:0]    mctl_ff, mctl_in, stat_ff, stat_in;
   logic [7:0]    abctl_ff, abctl_in, irtctl_ff, irtctl_in, irrctl_ff, irrctl_in;
   logic [DW-1:0] div_ff, div_in;
   logic [7:0]    txbuf_ff, txbuf_in;
   logic          txbuf_full_ff, txbuf_full_in;
   logic [W-1:0]  tx_hold_wait_ff, tx_hold_wait_in;
   logic [7:0]    tx_shift_ff, tx_shift_in;
   logic          tx_empty_ff, tx_empty_in, tx_ready_ff, tx_ready_in;
   logic [W-1:0]  tx_wait_ff, tx_wait_in;
   logic [7:0]    rxbuf_ff, rxbuf_in;
   logic          rxbuf_full_ff, rxbuf_full_in;
   logic [7:0]    rx_shift_ff, rx_shift_in;
   logic          rx_empty_ff, rx_empty_in, rx_ready_ff, rx_ready_in;
   logic [W-1:0]  rx_wait_ff, rx_wait_in;
   logic [3:0]    irq_ff, irq_in;

   logic [SW-1:0] step;
   logic          div_load;
   logic [W-1:0]  div_wide;

   // saturating subtract at the most negative counter value
   function automatic logic [W-1:0] sat_sub(input logic [W-1:0] w, input logic [SW-1:0] s);
      logic [W:0] diff;
      diff = {w[W-1], w} - {{(W+1-SW){1'b0}}, s};
      if (diff[W] != diff[W-1]) begin
         sat_sub = {1'b1, {(W-1){1'b0}}};
      end else begin
         sat_sub = diff[W-1:0];
      end
   endfunction

   function automatic logic le_zero(input logic [W-1:0] w);
      le_zero = w[W-1] || (w == '0);
   endfunction

   assign div_wide = {{(W-DW){1'b0}}, div_ff};

   // clock step from the selected source
   always_comb begin
      unique case (ctl1_ff[7:6])
         ubs_pkg::CLKSEL_NONE: step = '0;
         ubs_pkg::CLKSEL_ACLK: step = req.aclk_step;
         default:              step = req.smclk_step;
      endcase
   end

   // next state and result for the request in the input register
   always_comb begin
      ctl0_in = ctl0_ff;   ctl1_in = ctl1_ff;   br0_in = br0_ff;   br1_in = br1_ff;
      mctl_in = mctl_ff;   stat_in = stat_ff;   abctl_in = abctl_ff;
      irtctl_in = irtctl_ff;   irrctl_in = irrctl_ff;
      txbuf_in = txbuf_ff;   txbuf_full_in = txbuf_full_ff;
      tx_hold_wait_in = tx_hold_wait_ff;
      tx_shift_in = tx_shift_ff;   tx_empty_in = tx_empty_ff;   tx_ready_in = tx_ready_ff;
      tx_wait_in = tx_wait_ff;
      rxbuf_in = rxbuf_ff;   rxbuf_full_in = rxbuf_full_ff;
      rx_shift_in = rx_shift_ff;   rx_empty_in = rx_empty_ff;   rx_ready_in = rx_ready_ff;
      rx_wait_in = rx_wait_ff;
      irq_in = irq_ff;
      div_load = 1'b0;
      rsp = '0;

      unique case (req.func)
         ubs_pkg::FUNC_READ: begin
            unique case (req.reg_index)
               ubs_pkg::REG_CTL0:   rsp.read_data = ctl0_ff;
               ubs_pkg::REG_CTL1:   rsp.read_data = ctl1_ff;
               ubs_pkg::REG_BR0:    rsp.read_data = br0_ff;
               ubs_pkg::REG_BR1:    rsp.read_data = br1_ff;
               ubs_pkg::REG_MCTL:   rsp.read_data = mctl_ff;
               ubs_pkg::REG_STAT:   rsp.read_data = stat_ff;
               ubs_pkg::REG_RXBUF: begin
                  rsp.read_data = rxbuf_ff;
                  irq_in[ubs_pkg::IRQ_RXIFG] = 1'b0;
                  rxbuf_full_in = 1'b0;
                  stat_in[ubs_pkg::STAT_OE] = 1'b0;
               end
               ubs_pkg::REG_TXBUF: begin
                  rsp.read_data = txbuf_ff;
                  irq_in[ubs_pkg::IRQ_TXIFG] = 1'b0;
               end
               ubs_pkg::REG_ABCTL:  rsp.read_data = abctl_ff;
               ubs_pkg::REG_IRTCTL: rsp.read_data = irtctl_ff;
               ubs_pkg::REG_IRRCTL: rsp.read_data = irrctl_ff;
               ubs_pkg::REG_IEIFG:  rsp.read_data = {4'b0000, irq_ff};
               default:             rsp.event_code = ubs_pkg::EVT_BAD_REG;
            endcase
         end
         ubs_pkg::FUNC_WRITE: begin
            unique case (req.reg_index)
               ubs_pkg::REG_CTL0: begin
                  ctl0_in  = req.data_in;
                  div_load = 1'b1;
               end
               ubs_pkg::REG_CTL1: begin
                  // software reset clears the transfer path before the store
                  if (req.data_in[ubs_pkg::CTL1_SWRST]) begin
                     irq_in[ubs_pkg::IRQ_RXIE]  = 1'b0;
                     irq_in[ubs_pkg::IRQ_TXIE]  = 1'b0;
                     irq_in[ubs_pkg::IRQ_RXIFG] = 1'b0;
                     irq_in[ubs_pkg::IRQ_TXIFG] = 1'b1;
                     stat_in[ubs_pkg::STAT_OE]  = 1'b0;
                     stat_in[ubs_pkg::STAT_FE]  = 1'b0;
                     txbuf_full_in   = 1'b0;
                     tx_hold_wait_in = '0;
                     tx_empty_in     = 1'b1;
                     tx_ready_in     = 1'b0;
                     rxbuf_full_in   = 1'b0;
                     rx_empty_in     = 1'b1;
                     rx_ready_in     = 1'b0;
                  end
                  ctl1_in = req.data_in;
               end
               ubs_pkg::REG_BR0: begin
                  br0_in   = req.data_in;
                  div_load = 1'b1;
               end
               ubs_pkg::REG_BR1: begin
                  br1_in   = req.data_in;
                  div_load = 1'b1;
               end
               ubs_pkg::REG_MCTL: begin
                  mctl_in  = req.data_in;
                  div_load = 1'b1;
               end
               ubs_pkg::REG_STAT:   stat_in = req.data_in;
               ubs_pkg::REG_RXBUF:  rsp.event_code = ubs_pkg::EVT_READONLY;
               ubs_pkg::REG_TXBUF: begin
                  txbuf_in        = req.data_in;
                  txbuf_full_in   = 1'b1;
                  tx_hold_wait_in = {{(W-1){1'b0}}, 1'b1};
                  irq_in[ubs_pkg::IRQ_TXIFG] = 1'b0;
               end
               ubs_pkg::REG_ABCTL:  abctl_in = req.data_in;
               ubs_pkg::REG_IRTCTL: irtctl_in = req.data_in;
               ubs_pkg::REG_IRRCTL: irrctl_in = req.data_in;
               ubs_pkg::REG_IEIFG:  irq_in = req.data_in[3:0];
               default:             rsp.event_code = ubs_pkg::EVT_BAD_REG;
            endcase
         end
         ubs_pkg::FUNC_TICK: begin
            // tx buffer to shifter, or count down the hold delay
            if (txbuf_full_ff) begin
               if (le_zero(tx_hold_wait_ff) && tx_empty_ff) begin
                  tx_shift_in     = txbuf_ff;
                  txbuf_full_in   = 1'b0;
                  tx_hold_wait_in = '0;
                  tx_empty_in     = 1'b0;
                  tx_ready_in     = 1'b0;
                  tx_wait_in      = div_wide;
                  irq_in[ubs_pkg::IRQ_TXIFG] = 1'b1;
                  rsp.tx_dma_pulse = ~irq_ff[ubs_pkg::IRQ_TXIE];
               end else begin
                  tx_hold_wait_in = sat_sub(tx_hold_wait_ff, step);
               end
            end
            // tx shifter countdown
            if (!tx_empty_in) begin
               tx_wait_in = sat_sub(tx_wait_in, step);
               if (le_zero(tx_wait_in)) begin
                  tx_ready_in = 1'b1;
               end
            end
            // rx shifter countdown
            if (!rx_empty_ff) begin
               rx_wait_in = sat_sub(rx_wait_ff, step);
               if (le_zero(rx_wait_in)) begin
                  rx_ready_in = 1'b1;
               end
            end
            // rx shifter to buffer, flag overrun when still full
            if (rx_ready_in) begin
               if (rxbuf_full_ff) begin
                  stat_in[ubs_pkg::STAT_OE] = 1'b1;
               end
               rxbuf_in      = rx_shift_ff;
               rxbuf_full_in = 1'b1;
               rx_empty_in   = 1'b1;
               rx_ready_in   = 1'b0;
               irq_in[ubs_pkg::IRQ_RXIFG] = 1'b1;
               rsp.rx_dma_pulse = ~irq_ff[ubs_pkg::IRQ_RXIE];
            end
         end
         ubs_pkg::FUNC_RX_BYTE: begin
            if (rx_empty_ff) begin
               rx_shift_in = req.data_in;
               rx_empty_in = 1'b0;
               rx_ready_in = 1'b0;
               rx_wait_in  = div_wide;
            end else begin
               rsp.event_code = ubs_pkg::EVT_RX_DROP;
            end
         end
         ubs_pkg::FUNC_TX_POLL: begin
            if (tx_ready_ff) begin
               rsp.tx_valid = 1'b1;
               rsp.tx_byte  = tx_shift_ff;
               tx_empty_in  = 1'b1;
               tx_ready_in  = 1'b0;
            end
         end
         default: ;
      endcase

      div_in = div_load ? ubs_pkg::byte_div(ctl0_in, br1_in, br0_in) : div_ff;

      rsp.rx_free = rx_empty_in;
      rsp.rx_irq  = irq_in[ubs_pkg::IRQ_RXIFG] & irq_in[ubs_pkg::IRQ_RXIE];
      rsp.tx_irq  = irq_in[ubs_pkg::IRQ_TXIFG] & irq_in[ubs_pkg::IRQ_TXIE];
   end

   // state registers, updated once per fired request
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;   ctl1_ff <= '0;   br0_ff <= '0;   br1_ff <= '0;
         mctl_ff <= '0;   stat_ff <= '0;   abctl_ff <= '0;
         irtctl_ff <= '0;   irrctl_ff <= '0;
         div_ff <= '0;
         txbuf_ff <= '0;   txbuf_full_ff <= 1'b0;   tx_hold_wait_ff <= '0;
         tx_shift_ff <= '0;   tx_empty_ff <= 1'b1;   tx_ready_ff <= 1'b0;
         tx_wait_ff <= '0;
         rxbuf_ff <= '0;   rxbuf_full_ff <= 1'b0;
         rx_shift_ff <= '0;   rx_empty_ff <= 1'b1;   rx_ready_ff <= 1'b0;
         rx_wait_ff <= '0;
         irq_ff <= '0;
      end else if (fire) begin
         ctl0_ff <= ctl0_in;   ctl1_ff <= ctl1_in;   br0_ff <= br0_in;   br1_ff <= br1_in;
         mctl_ff <= mctl_in;   stat_ff <= stat_in;   abctl_ff <= abctl_in;
         irtctl_ff <= irtctl_in;   irrctl_ff <= irrctl_in;
         div_ff <= div_in;
         txbuf_ff <= txbuf_in;   txbuf_full_ff <= txbuf_full_in;
         tx_hold_wait_ff <= tx_hold_wait_in;
         tx_shift_ff <= tx_shift_in;   tx_empty_ff <= tx_empty_in;
         tx_ready_ff <= tx_ready_in;   tx_wait_ff <= tx_wait_in;
         rxbuf_ff <= rxbuf_in;   rxbuf_full_ff <= rxbuf_full_in;
         rx_shift_ff <= rx_shift_in;   rx_empty_ff <= rx_empty_in;
         rx_ready_ff <= rx_ready_in;   rx_wait_ff <= rx_wait_in;
         irq_ff <= irq_in;
      end
   end

endmodule

/* hdl/uart_buffer_shifter_peripheral.sv */
// channel   | dir | payload
// req_chan  | in  | func, reg_index, data_in, aclk_step, smclk_step
// rsp_chan  | out | read_data, tx_valid, tx_byte, rx_free, irqs, dma pulses, event_code
//
// one request per cycle sustained while rsp_chan.ready stays high; a response is offered
// once its request has passed the input register and reached the response register,
// where it waits; the once-per-fire state update in ubs_core sets the rate
// synchronous active-high reset clears both registers' valid bits and all ubs_core state
// a stalled response holds the response register; the input register fills behind it
// and req_chan.ready drops only when both are occupied
//
// top level of the uart buffer/shifter peripheral; depends on ubs_pkg, ubs_if, ubs_core
module uart_buffer_shifter_peripheral #(
   parameter int WAIT_WIDTH = ubs_pkg::WAIT_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ubs_req_if.sink    req_chan,
   ubs_rsp_if.source  rsp_chan
);

   logic             in_valid_ff;
   ubs_pkg::req_type in_req_ff;
   logic             rsp_valid_ff;
   ubs_pkg::rsp_type rsp_ff;
   ubs_pkg::rsp_type core_rsp;
   logic             fire;
   logic             req_take;

   // handshake: execute when the response register can take a result
   assign fire     = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= '{func:       req_chan.func,
                        reg_index:  req_chan.reg_index,
                        data_in:    req_chan.data_in,
                        aclk_step:  req_chan.aclk_step,
                        smclk_step: req_chan.smclk_step};
      end
   end

   ubs_core #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_ff.read_data;
   assign rsp_chan.tx_valid     = rsp_ff.tx_valid;
   assign rsp_chan.tx_byte      = rsp_ff.tx_byte;
   assign rsp_chan.rx_free      = rsp_ff.rx_free;
   assign rsp_chan.rx_irq       = rsp_ff.rx_irq;
   assign rsp_chan.tx_irq       = rsp_ff.tx_irq;
   assign rsp_chan.rx_dma_pulse = rsp_ff.rx_dma_pulse;
   assign rsp_chan.tx_dma_pulse = rsp_ff.tx_dma_pulse;
   assign rsp_chan.event_code   = rsp_ff.event_code;

endmodule

/* hdl/ubs_checker.sv */
// port-level checks of the uart buffer/shifter peripheral responses
// depends on ubs_pkg and the defines header; bound to the top level below
`include "uart_buffer_shifter_peripheral_defines.svh"

module ubs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_rx_free,
   input logic       rsp_rx_irq,
   input logic       rsp_tx_irq,
   input logic       rsp_rx_dma_pulse,
   input logic       rsp_tx_dma_pulse,
   input logic [1:0] rsp_event_code
);

   // a stalled response keeps its valid, read data and tx byte
   `UBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_tx_byte), "stalled response changed")

   // a receive dma request only comes with rxie clear and an emptied shifter
   `UBS_ASSERT_IMPLY(a_rx_dma, clock, reset, rsp_valid && rsp_rx_dma_pulse, !rsp_rx_irq && rsp_rx_free && rsp_event_code == ubs_pkg::EVT_OK, "rx dma with irq enabled")

   // a transmit dma request only comes with txie clear
   `UBS_ASSERT_IMPLY(a_tx_dma, clock, reset, rsp_valid && rsp_tx_dma_pulse, !rsp_tx_irq && !rsp_tx_valid, "tx dma with irq enabled")

   // tx byte is zero unless a byte is handed out
   `UBS_ASSERT_IMPLY(a_tx_byte, clock, reset, rsp_valid && !rsp_tx_valid, rsp_tx_byte == 8'd0, "tx byte without tx valid")

   // read data only on an error-free read
   `UBS_ASSERT_IMPLY(a_read_only, clock, reset, rsp_valid && rsp_read_data != 8'd0, rsp_event_code == ubs_pkg::EVT_OK && !rsp_tx_valid && !rsp_rx_dma_pulse, "read data on non-read")

endmodule

bind uart_buffer_shifter_peripheral ubs_checker u_ubs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_read_data    (rsp_chan.read_data),
   .rsp_tx_valid     (rsp_chan.tx_valid),
   .rsp_tx_byte      (rsp_chan.tx_byte),
   .rsp_rx_free      (rsp_chan.rx_free),
   .rsp_rx_irq       (rsp_chan.rx_irq),
   .rsp_tx_irq       (rsp_chan.tx_irq),
   .rsp_rx_dma_pulse (rsp_chan.rx_dma_pulse),
   .rsp_tx_dma_pulse (rsp_chan.tx_dma_pulse),
   .rsp_event_code   (rsp_chan.event_code)
);
